[design/prt_pkg.sv]
// Shared types and constants of the probe request SSID tracker.
`default_nettype none
package prt_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int SSID_BYTES_DEF  = 32;
    localparam int SSID_CAP        = 32;
    localparam int HDR_LEN         = 24;
    localparam int BCAST_LEN       = 11;
    // "<Broadcast>", first character in the low byte
    localparam logic [8*BCAST_LEN-1:0] BCAST_NAME = {
        8'h3E, 8'h74, 8'h73, 8'h61, 8'h63, 8'h64, 8'h61, 8'h6F, 8'h72, 8'h42, 8'h3C};

    typedef enum logic [1:0] {
        REQ_BYTE  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_UPDATE  = 3'd1,
        ACT_INSERT  = 3'd2,
        ACT_FULL    = 3'd3,
        ACT_READ    = 3'd4,
        ACT_BADIDX  = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        IDX_ZERO,
        IDX_SRCH,
        IDX_COUNT,
        IDX_RI
    } idx_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NAME,
        ST_SRD,
        ST_SCMP,
        ST_ONE_CLR,
        ST_ONE_BAD,
        ST_RISSUE,
        ST_RWORD
    } state_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  frame_byte;
        logic        first_of_frame;
        logic        last_of_frame;
        logic [11:0] signal_length;
        logic signed [7:0] signal_strength;
        logic [31:0] time_seconds;
        logic [7:0]  read_index;
    } in_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  entry_index;
        logic [8:0]  entry_count;
        logic [63:0] data_word;
        logic        last_of_run;
    } out_t;

    typedef struct packed {
        logic [31:0]         seconds;
        logic [7:0]          strength;
        logic [8*SSID_CAP-1:0] ssid;
        logic [47:0]         addr;
    } entry_t;

    typedef struct packed {
        logic     byte_en;
        logic     ri_load;
        logic     clr_parser;
        logic     name_load;
        logic     cnt_clear;
        logic     cnt_inc;
        logic     srch_init;
        logic     srch_inc;
        logic     rd_srch;
        logic     rd_read;
        logic     wr_upd;
        logic     wr_ins;
        logic     word_clr;
        logic     word_inc;
        logic     out_load;
        action_t  out_act;
        idx_sel_t out_idx;
        logic     out_last;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       is_last;
        logic       ri_bad;
        logic       hit;
        logic       srch_end;
        logic       full;
        logic       match;
        logic       word_last;
        logic       out_free;
    } stat_t;

endpackage
`default_nettype wire

[design/prt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module prt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             wr_en,
    input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                 wr_data,
    input  wire logic                             rd_en,
    input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                 rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

[design/prt_datapath.sv]
// Datapath: frame parser, SSID name builder, table RAM, search counter, result register.
`default_nettype none
module prt_datapath #(
    parameter int TABLE_DEPTH = prt_pkg::TABLE_DEPTH_DEF,
    parameter int SSID_BYTES  = prt_pkg::SSID_BYTES_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire prt_pkg::in_t   s_data,
    input  wire prt_pkg::cmd_t  cmd,
    output prt_pkg::stat_t      stat,
    input  wire logic           m_ready,
    output logic                m_valid,
    output prt_pkg::out_t       m_data
);
    import prt_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int RW = (CW > 8) ? CW : 8;
    localparam int SW = 8 * SSID_CAP;

    // parser state
    logic [11:0]        pos_reg, pos_next;
    logic               probe_reg, probe_next;
    logic [47:0]        sender_reg, sender_next;
    logic signed [13:0] ep_reg, ep_next;
    logic [15:0]        etl_reg, etl_next;
    logic [SW-1:0]      buf_reg, buf_next;
    logic               found_reg, found_next;
    logic               done_reg, done_next;

    logic [7:0]         strength_reg;
    logic [31:0]        seconds_reg;
    logic [7:0]         ri_reg;
    logic [SW-1:0]      name_reg, name_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      srch_reg;
    logic [2:0]         word_reg;
    logic               m_valid_reg;
    out_t               m_data_reg;

    entry_t             wr_entry, rd_entry;
    logic [IW-1:0]      ram_waddr, ram_raddr;
    logic [7:0]         out_idx;
    logic [63:0]        out_word;

    // parse one byte: apply first-of-frame restart, then header, address and element walk
    always_comb begin
        logic [11:0]        pos;
        logic               probe;
        logic [47:0]        snd;
        logic signed [13:0] ep, p, plen, k;
        logic [15:0]        etl;
        logic [SW-1:0]      sb;
        logic               fnd, dn;
        logic [7:0]         b, tag, len;

        b = s_data.frame_byte;
        if (s_data.first_of_frame) begin
            pos = '0; probe = 1'b0; snd = '0; ep = '0; etl = '0;
            sb = '0; fnd = 1'b0; dn = 1'b0;
        end else begin
            pos = pos_reg; probe = probe_reg; snd = sender_reg; ep = ep_reg;
            etl = etl_reg; sb = buf_reg; fnd = found_reg; dn = done_reg;
        end
        if (pos == 12'd0) begin
            probe = (b[3:2] == 2'd0) && (b[7:4] == 4'd4);
        end
        if (pos >= 12'd10 && pos <= 12'd15) begin
            snd = {snd[39:0], b};
        end
        p    = $signed({2'b00, pos}) - 14'sd24;
        plen = $signed({2'b00, s_data.signal_length}) - 14'sd24;
        tag  = etl[15:8];
        len  = etl[7:0];
        k    = p - ep - 14'sd2;
        if (probe && pos >= 12'(HDR_LEN)) begin
            if (!dn) begin
                if (p == ep) begin
                    if (ep + 14'sd2 > plen) begin
                        dn = 1'b1;
                    end else begin
                        etl = {b, 8'h00};
                    end
                end else if (p == ep + 14'sd1) begin
                    etl = {tag, b};
                    if (ep + 14'sd2 + $signed({6'b0, b}) > plen) begin
                        dn = 1'b1;
                    end else if (tag == 8'd0) begin
                        fnd = 1'b1;
                        dn  = 1'b1;
                    end else if (b == 8'd0) begin
                        ep = ep + 14'sd2;
                    end
                end else if (p > ep + 14'sd1 && p == ep + 14'sd1 + $signed({6'b0, len})) begin
                    ep = ep + 14'sd2 + $signed({6'b0, len});
                end
            end else if (fnd && p >= ep + 14'sd2) begin
                for (int i = 0; i < SSID_CAP; i++) begin
                    if (k == 14'(i) && k < $signed({6'b0, len}) && i < SSID_BYTES) begin
                        sb[8*i +: 8] = b;
                    end
                end
            end
        end
        if (pos < 12'd4095) begin
            pos = pos + 12'd1;
        end
        pos_next = pos; probe_next = probe; sender_next = snd; ep_next = ep;
        etl_next = etl; buf_next = sb; found_next = fnd; done_next = dn;
    end

    // cut at the first zero byte; an empty name becomes the broadcast label
    always_comb begin
        logic zs;
        zs = 1'b0;
        name_next = '0;
        for (int i = 0; i < SSID_CAP; i++) begin
            if (buf_reg[8*i +: 8] == 8'd0) begin
                zs = 1'b1;
            end
            if (!zs && i < SSID_BYTES) begin
                name_next[8*i +: 8] = buf_reg[8*i +: 8];
            end
        end
        if (buf_reg[7:0] == 8'd0) begin
            name_next = '0;
            for (int i = 0; i < BCAST_LEN; i++) begin
                if (i < SSID_BYTES) begin
                    name_next[8*i +: 8] = BCAST_NAME[8*i +: 8];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clr_parser) begin
            pos_reg <= '0; probe_reg <= 1'b0; sender_reg <= '0; ep_reg <= '0;
            etl_reg <= '0; buf_reg <= '0; found_reg <= 1'b0; done_reg <= 1'b0;
        end else if (cmd.byte_en) begin
            pos_reg <= pos_next; probe_reg <= probe_next; sender_reg <= sender_next;
            ep_reg <= ep_next; etl_reg <= etl_next; buf_reg <= buf_next;
            found_reg <= found_next; done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.byte_en && s_data.last_of_frame) begin
            strength_reg <= s_data.signal_strength;
            seconds_reg  <= s_data.time_seconds;
        end
        if (cmd.ri_load) begin
            ri_reg <= s_data.read_index;
        end
        if (cmd.name_load) begin
            name_reg <= name_next;
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clear) begin
            cnt_next = '0;
        end else if (cmd.cnt_inc) begin
            cnt_next = cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            srch_reg <= '0;
            word_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (cmd.srch_init) begin
                srch_reg <= '0;
            end else if (cmd.srch_inc) begin
                srch_reg <= srch_reg + CW'(1);
            end
            if (cmd.word_clr) begin
                word_reg <= '0;
            end else if (cmd.word_inc) begin
                word_reg <= word_reg + 3'd1;
            end
        end
    end

    // table storage
    assign wr_entry = '{seconds: seconds_reg, strength: strength_reg,
                        ssid: name_reg, addr: sender_reg};
    assign ram_waddr = cmd.wr_ins ? IW'(cnt_reg) : IW'(srch_reg);
    assign ram_raddr = cmd.rd_read ? IW'(ri_reg) : IW'(srch_reg);

    prt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (cmd.wr_upd | cmd.wr_ins),
        .wr_addr (ram_waddr),
        .wr_data (wr_entry),
        .rd_en   (cmd.rd_srch | cmd.rd_read),
        .rd_addr (ram_raddr),
        .rd_data (rd_entry)
    );

    always_comb begin
        case (cmd.out_idx)
            IDX_SRCH:  out_idx = 8'(srch_reg);
            IDX_COUNT: out_idx = 8'(cnt_reg);
            IDX_RI:    out_idx = ri_reg;
            default:   out_idx = 8'd0;
        endcase
    end

    always_comb begin
        case (word_reg)
            3'd0:    out_word = {8'h00, rd_entry.strength, rd_entry.addr};
            3'd1:    out_word = {32'h0, rd_entry.seconds};
            3'd2:    out_word = rd_entry.ssid[63:0];
            3'd3:    out_word = rd_entry.ssid[127:64];
            3'd4:    out_word = rd_entry.ssid[191:128];
            3'd5:    out_word = rd_entry.ssid[255:192];
            default: out_word = 64'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.action      <= cmd.out_act;
            m_data_reg.entry_index <= out_idx;
            m_data_reg.entry_count <= 9'(cnt_next);
            m_data_reg.data_word   <= (cmd.out_act == ACT_READ) ? out_word : 64'd0;
            m_data_reg.last_of_run <= cmd.out_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign stat.req       = s_data.req_type;
    assign stat.is_last   = s_data.last_of_frame;
    assign stat.ri_bad    = RW'(s_data.read_index) >= RW'(cnt_reg);
    assign stat.hit       = probe_reg && found_reg;
    assign stat.srch_end  = srch_reg >= cnt_reg;
    assign stat.full      = cnt_reg == CW'(TABLE_DEPTH);
    assign stat.match     = (rd_entry.addr == sender_reg) && (rd_entry.ssid == name_reg);
    assign stat.word_last = word_reg == 3'd5;
    assign stat.out_free  = !m_valid_reg || m_ready;
endmodule
`default_nettype wire

[design/prt_ctrl.sv]
// Controller state machine: sequences parsing, table search, insert and readout.
`default_nettype none
module prt_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire prt_pkg::stat_t stat,
    output prt_pkg::cmd_t       cmd
);
    import prt_pkg::*;

    state_t state_reg, state_next;
    logic   acc;

    assign s_ready = (state_reg == ST_IDLE);
    assign acc     = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    case (stat.req)
                        REQ_BYTE:  state_next = stat.is_last ? ST_NAME : ST_IDLE;
                        REQ_READ:  state_next = stat.ri_bad ? ST_ONE_BAD : ST_RISSUE;
                        REQ_CLEAR: state_next = ST_ONE_CLR;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_NAME: begin
                if (stat.hit) begin
                    state_next = ST_SRD;
                end else if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SRD: begin
                if (!stat.srch_end) begin
                    state_next = ST_SCMP;
                end else if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCMP: begin
                if (!stat.match) begin
                    state_next = ST_SRD;
                end else if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_ONE_CLR, ST_ONE_BAD: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RISSUE: state_next = ST_RWORD;
            ST_RWORD: begin
                if (stat.out_free && stat.word_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '{out_act: ACT_NONE, out_idx: IDX_ZERO, default: 1'b0};
        case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    case (stat.req)
                        REQ_BYTE:  cmd.byte_en = 1'b1;
                        REQ_READ:  cmd.ri_load = 1'b1;
                        REQ_CLEAR: cmd.cnt_clear = 1'b1;
                        default:   cmd.byte_en = 1'b0;
                    endcase
                end
            end
            ST_NAME: begin
                cmd.name_load = 1'b1;
                cmd.srch_init = 1'b1;
                if (!stat.hit && stat.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_last   = 1'b1;
                    cmd.clr_parser = 1'b1;
                end
            end
            ST_SRD: begin
                if (!stat.srch_end) begin
                    cmd.rd_srch = 1'b1;
                end else if (stat.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_last   = 1'b1;
                    cmd.clr_parser = 1'b1;
                    if (stat.full) begin
                        cmd.out_act = ACT_FULL;
                    end else begin
                        cmd.out_act = ACT_INSERT;
                        cmd.out_idx = IDX_COUNT;
                        cmd.wr_ins  = 1'b1;
                        cmd.cnt_inc = 1'b1;
                    end
                end
            end
            ST_SCMP: begin
                if (!stat.match) begin
                    cmd.srch_inc = 1'b1;
                end else if (stat.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_last   = 1'b1;
                    cmd.out_act    = ACT_UPDATE;
                    cmd.out_idx    = IDX_SRCH;
                    cmd.wr_upd     = 1'b1;
                    cmd.clr_parser = 1'b1;
                end
            end
            ST_ONE_CLR: begin
                cmd.out_load = stat.out_free;
                cmd.out_last = 1'b1;
            end
            ST_ONE_BAD: begin
                cmd.out_load = stat.out_free;
                cmd.out_last = 1'b1;
                cmd.out_act  = ACT_BADIDX;
                cmd.out_idx  = IDX_RI;
            end
            ST_RISSUE: begin
                cmd.rd_read  = 1'b1;
                cmd.word_clr = 1'b1;
            end
            ST_RWORD: begin
                cmd.out_act = ACT_READ;
                cmd.out_idx = IDX_RI;
                cmd.out_last = stat.word_last;
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.word_inc = 1'b1;
                end
            end
            default: cmd.out_load = 1'b0;
        endcase
    end
endmodule
`default_nettype wire

[design/probe_request_ssid_tracker_unit.sv]
// Top level of the probe request SSID tracker: controller plus datapath.
// Frame bytes that are not last give no result and leave the input ready.
// A last byte gives an ACT_NONE result without an SSID; with one it searches the valid
// entries and gives an update on a match, else an insert or a full drop.
// A read gives six data words, the last one flagged; a clear or bad read gives one result.
// Reset (aresetn low, synchronous) empties the table count and parser; no clearing pass.
`default_nettype none
module probe_request_ssid_tracker_unit #(
    parameter int TABLE_DEPTH = prt_pkg::TABLE_DEPTH_DEF,
    parameter int SSID_BYTES  = prt_pkg::SSID_BYTES_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire prt_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output prt_pkg::out_t      m_data
);
    import prt_pkg::*;

    // command and status between the sequencer and the datapath
    cmd_t  cmd;
    stat_t stat;

    // sequence each request: parse, search, write back, emit
    prt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // hold parser state, table and the result register
    prt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .SSID_BYTES  (SSID_BYTES)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );
endmodule
`default_nettype wire

[design/prt_checker.sv]
// Port-level checker for the tracker, bound to the top level.
`default_nettype none
module prt_checker (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          s_valid,
    input wire logic          s_ready,
    input wire prt_pkg::in_t  s_data,
    input wire logic          m_valid,
    input wire logic          m_ready,
    input wire prt_pkg::out_t m_data
);
    import prt_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped while stalled");

    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.action != ACT_READ |-> m_data.last_of_run)
        else $error("single result without last flag");

    a_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.action != ACT_READ |-> m_data.data_word == 64'd0)
        else $error("data word set outside a read");

    a_byte_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.req_type == REQ_BYTE && !s_data.last_of_frame
        |=> s_ready)
        else $error("input stalled after an inner frame byte");

    a_reset_quiet: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result shown after reset");
endmodule

bind probe_request_ssid_tracker_unit prt_checker u_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
